/* design/button_gesture_classifier_top_macros.svh */
// ----------------------------------------------------------------------------
// Button gesture classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BGC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bgc_pkg.sv */
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Event codes, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [IdxW-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_CLICK_MAX  = 2'd1,
    REG_DOUBLE_GAP = 2'd2
  } reg_idx_t;

  localparam logic [CfgW-1:0] LongPressRst = 16'd600;
  localparam logic [CfgW-1:0] ClickMaxRst  = 16'd500;
  localparam logic [CfgW-1:0] DoubleGapRst = 16'd300;

endpackage

`default_nettype wire

/* design/button_gesture_classifier_top.sv */
// ----------------------------------------------------------------------------
// Button gesture classifier
// Turns poll ticks (level plus millisecond timestamp) into click, double
// click and long press events, one event code per tick.
// ----------------------------------------------------------------------------
// Each accepted tick yields exactly one event_res. An accepted tick waits in
// the input register and moves into the result register once that register
// is empty or being read, so out_stall can hold it there (input register, then
// result register). A new tick can be taken every cycle while the result is
// not stalled; throughput is one tick per clock, set by the single pass of
// 32-bit subtract and compare logic between the input and result registers.
// in_stall rises only when both the input register and the result register
// hold items and the result is stalled. Timestamps wrap modulo 2^32; window
// checks are plain unsigned compares. Register writes (index 0 long press,
// 1 click maximum, 2 double gap; index 3 ignored) are always ready and must
// be issued only while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_gesture_classifier_top_macros.svh"

module button_gesture_classifier_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // tick channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         pressed,
  input  wire logic [bgc_pkg::TimeW-1:0]    now_ms,
  // event channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        event_res,
  // register write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bgc_pkg::IdxW-1:0]     cfg_index,
  input  wire logic [bgc_pkg::CfgW-1:0]     cfg_data
);

  // configuration
  logic [bgc_pkg::CfgW-1:0]  long_press_ms;
  logic [bgc_pkg::CfgW-1:0]  click_limit;
  logic [bgc_pkg::CfgW-1:0]  dbl_window;

  // input register
  logic                      s1_valid;
  logic                      s1_pressed;
  logic [bgc_pkg::TimeW-1:0] s1_now;

  // gesture state
  logic                      was_pressed;
  logic [bgc_pkg::TimeW-1:0] press_start_time;
  logic                      long_done;
  logic                      double_pending;
  logic [bgc_pkg::TimeW-1:0] window_end_time;

  logic                      was_pressed_next;
  logic [bgc_pkg::TimeW-1:0] press_start_time_next;
  logic                      long_done_next;
  logic                      double_pending_next;
  logic [bgc_pkg::TimeW-1:0] window_end_time_next;
  bgc_pkg::event_t           ev_next;

  // result register
  bgc_pkg::event_t           ev_res;

  logic                      s1_fire;
  logic [bgc_pkg::TimeW-1:0] held;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign event_res = ev_res;
  assign held      = s1_now - press_start_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= bgc_pkg::LongPressRst;
      click_limit   <= bgc_pkg::ClickMaxRst;
      dbl_window    <= bgc_pkg::DoubleGapRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bgc_pkg::REG_LONG_PRESS: long_press_ms <= cfg_data;
        bgc_pkg::REG_CLICK_MAX:  click_limit   <= cfg_data;
        bgc_pkg::REG_DOUBLE_GAP: dbl_window    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    was_pressed_next      = was_pressed;
    press_start_time_next = press_start_time;
    long_done_next        = long_done;
    double_pending_next   = double_pending;
    window_end_time_next  = window_end_time;
    ev_next               = bgc_pkg::EV_NONE;

    if (s1_pressed && !was_pressed) begin
      // press edge: start timing, keep any open double window
      was_pressed_next      = 1'b1;
      press_start_time_next = s1_now;
      long_done_next        = 1'b0;
    end else if (s1_pressed) begin
      if (!long_done && (held >= {16'd0, long_press_ms})) begin
        long_done_next      = 1'b1;
        double_pending_next = 1'b0;
        ev_next             = bgc_pkg::EV_LONG;
      end
    end else if (was_pressed) begin
      was_pressed_next = 1'b0;
      if (long_done) begin
        // long press already reported
      end else if (held > {16'd0, click_limit}) begin
        double_pending_next = 1'b0;
      end else if (double_pending && (s1_now <= window_end_time)) begin
        double_pending_next = 1'b0;
        ev_next             = bgc_pkg::EV_DOUBLE;
      end else begin
        double_pending_next  = 1'b1;
        window_end_time_next = s1_now + {16'd0, dbl_window};
      end
    end else if (double_pending && (s1_now > window_end_time)) begin
      // idle tick past the window: single click
      double_pending_next = 1'b0;
      ev_next             = bgc_pkg::EV_CLICK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pressed <= pressed;
      s1_now     <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed      <= 1'b0;
      press_start_time <= '0;
      long_done        <= 1'b0;
      double_pending   <= 1'b0;
      window_end_time  <= '0;
    end else if (s1_fire) begin
      was_pressed      <= was_pressed_next;
      press_start_time <= press_start_time_next;
      long_done        <= long_done_next;
      double_pending   <= double_pending_next;
      window_end_time  <= window_end_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      ev_res <= ev_next;
    end
  end

  `BGC_ASSERT_NEXT(a_long_sets_state,
                   s1_fire && (ev_next == bgc_pkg::EV_LONG),
                   long_done && was_pressed && !double_pending,
                   "long press without held state")
  `BGC_ASSERT_NEXT(a_click_clears_pending,
                   s1_fire && ((ev_next == bgc_pkg::EV_CLICK) ||
                               (ev_next == bgc_pkg::EV_DOUBLE)),
                   !double_pending && !was_pressed,
                   "click left window open")
  `BGC_ASSERT_SAME(a_stall_only_when_full,
                   in_stall,
                   s1_valid && out_valid && out_stall,
                   "input stalled with room downstream")

endmodule

`default_nettype wire
